// ===== hdl/scrc_pkg.sv =====
// Shared types and constants of the serial command release controller.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package scrc_pkg;

   // Controller states, in the encoding seen on rsp_ctrl_state.
   typedef enum logic [2:0] {
      ST_LOCKED     = 3'd0,
      ST_ARMED      = 3'd1,
      ST_RELEASING  = 3'd2,
      ST_RETRACTING = 3'd3,
      ST_FAULT      = 3'd4
   } ctrl_state_type;

   // Command codes, in the encoding seen on rsp_command_code.
   typedef enum logic [2:0] {
      CC_LOCK    = 3'd0,
      CC_ARM     = 3'd1,
      CC_RELEASE = 3'd2,
      CC_STOP    = 3'd3,
      CC_INVALID = 3'd4,
      CC_NONE    = 3'd5
   } cmd_code_type;

   // One classified item, handed from the front end to the back end.
   typedef struct packed {
      logic         is_tick;
      cmd_code_type cmd;
   } event_type;

   localparam int unsigned CMD_LEN = 4;

   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   localparam logic [8*CMD_LEN-1:0] WORD_LOCK = "LOCK";
   localparam logic [8*CMD_LEN-1:0] WORD_ARM  = "ARMD";
   localparam logic [8*CMD_LEN-1:0] WORD_RELS = "RELS";
   localparam logic [8*CMD_LEN-1:0] WORD_STOP = "STOP";

   // Register indexes on the csr port.
   localparam logic [1:0] CSR_RELEASE_TICKS = 2'd0;
   localparam logic [1:0] CSR_RETRACT_TICKS = 2'd1;
   localparam logic [1:0] CSR_REPORT_PERIOD = 2'd2;

   localparam logic [15:0] RELEASE_TICKS_RST = 16'd2000;
   localparam logic [15:0] RETRACT_TICKS_RST = 16'd2000;
   localparam logic [15:0] REPORT_PERIOD_RST = 16'd500;

   // Saturating increment of a millisecond timer.
   function automatic logic [15:0] bump(input logic [15:0] t);
      bump = (t == 16'hFFFF) ? t : t + 16'd1;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/scrc_front.sv =====
// Front end: accepts items, gathers command bytes, drops up to newline, decodes words.
// Depends on scrc_pkg; feeds one event per accepted item into scrc_queue.
`default_nettype none

module scrc_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_op,
   input  wire logic [7:0]         req_rx_byte,
   output logic                    evt_valid,
   input  wire logic               evt_ready,
   output scrc_pkg::event_type     evt_data
);

   localparam int unsigned CNT_W = $clog2(scrc_pkg::CMD_LEN);

   logic [7:0]       buf_ff [scrc_pkg::CMD_LEN-1];
   logic [CNT_W-1:0] count_ff, count_in;
   logic             discarding_ff, discarding_in;
   logic             accept;
   logic             store;
   logic [8*scrc_pkg::CMD_LEN-1:0] word;
   scrc_pkg::cmd_code_type         decoded;

   assign req_ready = evt_ready;
   assign accept    = req_valid & req_ready;
   assign evt_valid = req_valid;

   // Last byte arrives live; earlier ones come from the buffer.
   always_comb begin
      word = '0;
      for (int i = 0; i < scrc_pkg::CMD_LEN - 1; i++) begin
         word[8*(scrc_pkg::CMD_LEN-i)-1 -: 8] = buf_ff[i];
      end
      word[7:0] = req_rx_byte;
   end

   always_comb begin
      if (word == scrc_pkg::WORD_LOCK) begin
         decoded = scrc_pkg::CC_LOCK;
      end else if (word == scrc_pkg::WORD_ARM) begin
         decoded = scrc_pkg::CC_ARM;
      end else if (word == scrc_pkg::WORD_RELS) begin
         decoded = scrc_pkg::CC_RELEASE;
      end else if (word == scrc_pkg::WORD_STOP) begin
         decoded = scrc_pkg::CC_STOP;
      end else begin
         decoded = scrc_pkg::CC_INVALID;
      end
   end

   always_comb begin
      count_in         = count_ff;
      discarding_in    = discarding_ff;
      store            = 1'b0;
      evt_data.is_tick = req_op;
      evt_data.cmd     = scrc_pkg::CC_NONE;
      if (!req_op) begin
         if (discarding_ff) begin
            if (req_rx_byte == scrc_pkg::CH_LF) begin
               discarding_in = 1'b0;
            end
         end else if (req_rx_byte != scrc_pkg::CH_LF && req_rx_byte != scrc_pkg::CH_CR) begin
            if (count_ff == CNT_W'(scrc_pkg::CMD_LEN - 1)) begin
               count_in      = '0;
               discarding_in = 1'b1;
               evt_data.cmd  = decoded;
            end else begin
               store    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         discarding_ff <= 1'b0;
      end else if (accept) begin
         count_ff      <= count_in;
         discarding_ff <= discarding_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store) begin
         buf_ff[count_ff] <= req_rx_byte;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/scrc_queue.sv =====
// Short event queue between front and back end.
// Depends on scrc_pkg for the event type.
`default_nettype none

module scrc_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire scrc_pkg::event_type in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output scrc_pkg::event_type      out_data
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   scrc_pkg::event_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/scrc_back.sv =====
// Back end: controller state machine, phase and report timers, response register.
// Depends on scrc_pkg; takes events from scrc_queue.
`default_nettype none

module scrc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [15:0]         release_ticks,
   input  wire logic [15:0]         retract_ticks,
   input  wire logic [15:0]         report_period,
   input  wire logic                evt_valid,
   output logic                     evt_ready,
   input  wire scrc_pkg::event_type evt_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [2:0]               rsp_ctrl_state,
   output logic [2:0]               rsp_command_code,
   output logic                     rsp_report_due
);

   scrc_pkg::ctrl_state_type state_ff, state_in;
   logic [15:0] phase_ff, phase_in;
   logic [15:0] report_ff, report_in;
   logic        report_fire;
   logic [15:0] phase_bumped;
   logic        pop;

   logic                     rsp_valid_ff, rsp_valid_in;
   scrc_pkg::ctrl_state_type rsp_state_ff;
   scrc_pkg::cmd_code_type   rsp_cmd_ff;
   logic                     rsp_report_ff;

   assign evt_ready    = !rsp_valid_ff || rsp_ready;
   assign pop          = evt_valid & evt_ready;
   assign phase_bumped = scrc_pkg::bump(phase_ff);

   // Report timer counts first on a tick.
   always_comb begin
      report_in   = report_ff;
      report_fire = 1'b0;
      if (evt_data.is_tick) begin
         report_in = scrc_pkg::bump(report_ff);
         if (report_in >= report_period) begin
            report_fire = 1'b1;
            report_in   = '0;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      if (evt_data.is_tick) begin
         unique case (state_ff)
            scrc_pkg::ST_RELEASING: begin
               phase_in = phase_bumped;
               if (phase_bumped >= release_ticks) begin
                  state_in = scrc_pkg::ST_RETRACTING;
                  phase_in = '0;
               end
            end
            scrc_pkg::ST_RETRACTING: begin
               phase_in = phase_bumped;
               if (phase_bumped >= retract_ticks) begin
                  state_in = scrc_pkg::ST_LOCKED;
               end
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end else begin
         unique case (evt_data.cmd)
            scrc_pkg::CC_LOCK: begin
               state_in = scrc_pkg::ST_LOCKED;
            end
            scrc_pkg::CC_ARM: begin
               if (state_ff == scrc_pkg::ST_LOCKED) begin
                  state_in = scrc_pkg::ST_ARMED;
               end
            end
            scrc_pkg::CC_RELEASE: begin
               if (state_ff == scrc_pkg::ST_ARMED) begin
                  state_in = scrc_pkg::ST_RELEASING;
                  phase_in = '0;
               end
            end
            scrc_pkg::CC_STOP: begin
               state_in = scrc_pkg::ST_FAULT;
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   // Outputs: response register holds until taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ctrl_state   = rsp_state_ff;
   assign rsp_command_code = rsp_cmd_ff;
   assign rsp_report_due   = rsp_report_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scrc_pkg::ST_LOCKED;
         phase_ff     <= '0;
         report_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            state_ff  <= state_in;
            phase_ff  <= phase_in;
            report_ff <= report_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_state_ff  <= state_in;
         rsp_cmd_ff    <= evt_data.cmd;
         rsp_report_ff <= report_fire;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/serial_command_release_controller_top.sv =====
// Top level of the serial command release controller: csr registers and wiring.
// Depends on scrc_pkg, scrc_front, scrc_queue and scrc_back.
//
// Usage:
//   req_* carries one item per transfer: req_op = 0 is a received serial byte
//   (req_rx_byte), req_op = 1 is a one millisecond tick. Every item produces
//   exactly one transfer on rsp_*: controller state after the item, the
//   command decoded by this item (none on ticks and partial words) and the
//   report strobe.
//   Throughput is one item per clock while rsp_ready stays high. The front
//   end classifies a byte in the cycle it is taken (4-byte compare against
//   LOCK/ARMD/RELS/STOP); the back end runs the state machine and timers one
//   event per cycle unless the response register is held. A transfer passes
//   through the event queue and then the response register on its way to rsp_*.
//   When the receiver stalls, the response register holds, the queue fills
//   (QUEUE_DEPTH events) and then req_ready drops; nothing is lost.
//   Reset (synchronous, active high) returns the controller to locked, clears
//   timers, gathering and drop-to-newline state, empties the queue and loads
//   the csr defaults: release 2000, retract 2000, report period 500 ticks.
//   csr_* writes take effect at the edge with csr_we high; write them only
//   while the block is idle. Index 3 is ignored.
`default_nettype none

module serial_command_release_controller_top #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input item channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_rx_byte,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_ctrl_state,
   output logic [2:0]       rsp_command_code,
   output logic             rsp_report_due,
   // configuration write port
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic [15:0] release_ticks_ff;
   logic [15:0] retract_ticks_ff;
   logic [15:0] report_period_ff;

   logic                fq_valid, fq_ready;
   scrc_pkg::event_type fq_data;
   logic                qb_valid, qb_ready;
   scrc_pkg::event_type qb_data;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         release_ticks_ff <= scrc_pkg::RELEASE_TICKS_RST;
         retract_ticks_ff <= scrc_pkg::RETRACT_TICKS_RST;
         report_period_ff <= scrc_pkg::REPORT_PERIOD_RST;
      end else if (csr_we) begin
         case (csr_index)
            scrc_pkg::CSR_RELEASE_TICKS: release_ticks_ff <= csr_wdata;
            scrc_pkg::CSR_RETRACT_TICKS: retract_ticks_ff <= csr_wdata;
            scrc_pkg::CSR_REPORT_PERIOD: report_period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Front end: byte gathering and word decode.
   scrc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_rx_byte (req_rx_byte),
      .evt_valid   (fq_valid),
      .evt_ready   (fq_ready),
      .evt_data    (fq_data)
   );

   // Decouples front and back so each can stall on its own.
   scrc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   // Back end: controller, timers, response register.
   scrc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .release_ticks    (release_ticks_ff),
      .retract_ticks    (retract_ticks_ff),
      .report_period    (report_period_ff),
      .evt_valid        (qb_valid),
      .evt_ready        (qb_ready),
      .evt_data         (qb_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ctrl_state   (rsp_ctrl_state),
      .rsp_command_code (rsp_command_code),
      .rsp_report_due   (rsp_report_due)
   );

endmodule

`default_nettype wire
